@@ src/agmcd_pkg.sv @@
package agmcd_pkg;

    // Command codes of an input transaction
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Event codes of a result transaction
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_REFRESH = 3'd1;
    localparam logic [2:0] EV_NEW     = 3'd2;
    localparam logic [2:0] EV_FULL    = 3'd3;
    localparam logic [2:0] EV_CLEARED = 3'd4;

    // Frame byte offsets and expected values
    localparam logic [5:0] POS_SNAP_0    = 6'd24;
    localparam logic [5:0] POS_SNAP_1    = 6'd25;
    localparam logic [5:0] POS_SNAP_CTL  = 6'd26;
    localparam logic [5:0] POS_ETYPE_HI  = 6'd30;
    localparam logic [5:0] POS_ETYPE_LO  = 6'd31;
    localparam logic [5:0] POS_OPCODE    = 6'd39;
    localparam logic [5:0] POS_MAC_FIRST = 6'd40;
    localparam logic [5:0] POS_MAC_LAST  = 6'd45;
    localparam logic [5:0] POS_IP_LAST   = 6'd49;
    localparam logic [5:0] POS_MAX       = 6'd63;
    localparam logic [5:0] MIN_FRAME     = 6'd50;

    localparam logic [7:0] BYTE_SNAP     = 8'hAA;
    localparam logic [7:0] BYTE_SNAP_CTL = 8'h03;
    localparam logic [7:0] BYTE_ETYPE_HI = 8'h08;
    localparam logic [7:0] BYTE_ETYPE_LO = 8'h06;
    localparam logic [7:0] BYTE_OP_REPLY = 8'h02;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [1:0] entry_select;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [2:0]  gateway_count;
        logic        alert;
        logic [1:0]  entry_index;
        logic [47:0] entry_mac;
        logic [31:0] entry_first_seen;
        logic [31:0] entry_last_seen;
    } t_out_item;

    // Search token walking down the table chain
    typedef struct packed {
        logic        valid;
        logic [47:0] mac;
    } t_token;

    // Outcome reported by a cell while it holds the token
    typedef struct packed {
        logic        hit;
        logic        ins;
        logic [31:0] first_seen;
    } t_cell_stat;

    // Stored entry as seen from outside, zero when unused
    typedef struct packed {
        logic        valid;
        logic [47:0] mac;
        logic [31:0] first_seen;
        logic [31:0] last_seen;
    } t_entry;

    // Parser verdict on the byte just taken
    typedef struct packed {
        logic        pass;
        logic [47:0] mac;
    } t_judge;

endpackage

@@ src/agmcd_parser.sv @@
module agmcd_parser
    import agmcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic [7:0] i_octet,
    output t_judge     o_judge
);

    logic [5:0]  r_pos, n_pos;
    logic        r_ok, n_ok;
    logic [47:0] r_mac, n_mac;
    logic        byte_ok;

    // Check the byte at the current offset
    always_comb begin
        case (r_pos)
            POS_SNAP_0, POS_SNAP_1: byte_ok = (i_byte == BYTE_SNAP);
            POS_SNAP_CTL:           byte_ok = (i_byte == BYTE_SNAP_CTL);
            POS_ETYPE_HI:           byte_ok = (i_byte == BYTE_ETYPE_HI);
            POS_ETYPE_LO:           byte_ok = (i_byte == BYTE_ETYPE_LO);
            POS_OPCODE:             byte_ok = (i_byte == BYTE_OP_REPLY);
            POS_IP_LAST:            byte_ok = (i_byte == i_octet);
            default:                byte_ok = 1'b1;
        endcase
    end

    // Advance position, validity and captured sender MAC
    always_comb begin
        n_ok  = r_ok && byte_ok;
        n_pos = (r_pos < POS_MAX) ? r_pos + 6'd1 : r_pos;
        n_mac = r_mac;
        if (r_pos inside {[POS_MAC_FIRST:POS_MAC_LAST]}) begin
            n_mac = {r_mac[39:0], i_byte};
        end
        o_judge.pass = i_last && n_ok && (n_pos >= MIN_FRAME);
        o_judge.mac  = n_mac;
    end

    // Restart parsing after the last byte of a frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_ok  <= 1'b1;
            r_mac <= '0;
        end else if (i_take) begin
            if (i_last) begin
                r_pos <= '0;
                r_ok  <= 1'b1;
                r_mac <= '0;
            end else begin
                r_pos <= n_pos;
                r_ok  <= n_ok;
                r_mac <= n_mac;
            end
        end
    end

endmodule

@@ src/agmcd_cell.sv @@
module agmcd_cell
    import agmcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clear,
    input  logic [31:0] i_now,
    input  t_token      i_tok,
    output t_token      o_tok,
    output t_cell_stat  o_stat,
    output t_entry      o_entry
);

    t_token      r_tok;
    logic        r_valid;
    logic [47:0] r_mac;
    logic [31:0] r_first;
    logic [31:0] r_last;
    logic        match;
    logic        free;

    // Compare the held token against this entry
    always_comb begin
        match = r_tok.valid && r_valid && (r_mac == r_tok.mac);
        free  = r_tok.valid && !r_valid;

        o_tok.valid = r_tok.valid && r_valid && !match;
        o_tok.mac   = r_tok.mac;

        o_stat.hit        = match;
        o_stat.ins        = free;
        o_stat.first_seen = r_first;

        o_entry.valid      = r_valid;
        o_entry.mac        = r_valid ? r_mac   : '0;
        o_entry.first_seen = r_valid ? r_first : '0;
        o_entry.last_seen  = r_valid ? r_last  : '0;
    end

    // Take the token from the left neighbor every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
        r_tok.mac <= i_tok.mac;
    end

    // Refresh on a hit, fill on the first free entry, drop on clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (free) begin
            r_valid <= 1'b1;
        end
        if (free) begin
            r_mac   <= r_tok.mac;
            r_first <= i_now;
            r_last  <= i_now;
        end else if (match) begin
            r_last  <= i_now;
        end
    end

endmodule

@@ src/arp_gateway_mac_conflict_detector.sv @@
// ARP gateway MAC conflict detector.
// Input channel (i_in_valid / o_in_stall, payload i_in_item) carries one
// transaction per frame byte, millisecond tick, table clear or entry read.
// Output channel (o_out_valid / i_out_stall, payload o_out_item) returns
// exactly one result transaction for every input transaction, in order.
// The gateway host octet is to be written via i_cfg_we / i_cfg_data only while
// idle; the block itself does not enforce it. Ticks, clears, reads and frame
// bytes that do not end a passing ARP reply give their result in the cycle after
// acceptance; one such transaction can be taken every cycle while the receiver
// does not stall. The last byte of a passing frame launches a token down the row
// of table cells, one cell per cycle: a hit or insert ends the walk at that entry,
// and a token leaving the last cell reports a full table; input stalls during the
// walk. While the receiver stalls, the result register holds and the input stalls
// once that register is occupied.
// Reset empties the table, clears the clock and the alert, restarts frame
// parsing and sets the gateway host octet to 1.
module arp_gateway_mac_conflict_detector
    import agmcd_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  logic      i_cfg_we,
    input  logic [7:0] i_cfg_data
);

    localparam int UW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic {S_IDLE, S_SEARCH} t_state;

    t_state          r_state, n_state;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out, n_out;
    logic [UW-1:0]   r_used, n_used;
    logic            r_alert, n_alert;
    logic [31:0]     r_now;
    logic [7:0]      r_octet;
    logic [47:0]     r_cand, n_cand;

    logic            in_acc;
    logic            take_byte;
    logic            clear_tab;
    t_judge          judge;
    t_token          w_tok   [TABLE_ENTRIES+1];
    t_cell_stat      w_stat  [TABLE_ENTRIES];
    t_entry          w_entry [TABLE_ENTRIES];

    logic            found_hit, found_ins;
    logic [1:0]      found_idx;
    logic [31:0]     found_first;
    logic [1:0]      rd_idx;
    logic [47:0]     rd_mac;
    logic [31:0]     rd_first, rd_last;
    logic [7:0]      cnt_ext;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign take_byte = in_acc && (i_in_item.cmd == CMD_BYTE);
    assign clear_tab = in_acc && (i_in_item.cmd == CMD_CLEAR);

    assign o_in_stall  = (r_state == S_SEARCH) || (r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    agmcd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take_byte),
        .i_byte  (i_in_item.data_byte),
        .i_last  (i_in_item.last_byte),
        .i_octet (r_octet),
        .o_judge (judge)
    );

    // Launch a token into the first cell for a passing frame
    assign w_tok[0].valid = take_byte && judge.pass;
    assign w_tok[0].mac   = judge.mac;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        agmcd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (clear_tab),
            .i_now   (r_now),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .o_stat  (w_stat[g]),
            .o_entry (w_entry[g])
        );
    end

    // Collect the search outcome and the selected entry over all cells
    always_comb begin
        found_hit   = 1'b0;
        found_ins   = 1'b0;
        found_idx   = '0;
        found_first = '0;
        rd_idx      = '0;
        rd_mac      = '0;
        rd_first    = '0;
        rd_last     = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            found_hit = found_hit | w_stat[i].hit;
            found_ins = found_ins | w_stat[i].ins;
            if (w_stat[i].hit || w_stat[i].ins) begin
                found_idx = found_idx | 2'(i);
            end
            if (w_stat[i].hit) begin
                found_first = found_first | w_stat[i].first_seen;
            end
            if (int'(i_in_item.entry_select) == i) begin
                rd_idx   = rd_idx   | 2'(i);
                rd_mac   = rd_mac   | w_entry[i].mac;
                rd_first = rd_first | w_entry[i].first_seen;
                rd_last  = rd_last  | w_entry[i].last_seen;
            end
        end
    end

    // Next state, table fill count and result transaction
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_used      = r_used;
        n_alert     = r_alert;
        n_cand      = r_cand;
        cnt_ext     = '0;

        if (r_state == S_SEARCH) begin
            if (found_hit || found_ins || w_tok[TABLE_ENTRIES].valid) begin
                n_state                  = S_IDLE;
                n_out_valid              = 1'b1;
                n_out                    = '0;
                if (found_hit) begin
                    n_out.event_res        = EV_REFRESH;
                    n_out.entry_index      = found_idx;
                    n_out.entry_mac        = r_cand;
                    n_out.entry_first_seen = found_first;
                    n_out.entry_last_seen  = r_now;
                end else if (found_ins) begin
                    n_used                 = UW'(r_used + 1'b1);
                    n_alert                = r_alert || (r_used != '0);
                    n_out.event_res        = EV_NEW;
                    n_out.entry_index      = found_idx;
                    n_out.entry_mac        = r_cand;
                    n_out.entry_first_seen = r_now;
                    n_out.entry_last_seen  = r_now;
                end else begin
                    n_out.event_res        = EV_FULL;
                end
                cnt_ext             = 8'(n_used);
                n_out.gateway_count = cnt_ext[2:0];
                n_out.alert         = n_alert;
            end
        end else if (in_acc) begin
            n_out = '0;
            case (i_in_item.cmd)
                CMD_BYTE: begin
                    if (judge.pass) begin
                        n_state = S_SEARCH;
                        n_cand  = judge.mac;
                    end
                end
                CMD_CLEAR: begin
                    n_used          = '0;
                    n_alert         = 1'b0;
                    n_out.event_res = EV_CLEARED;
                end
                CMD_READ: begin
                    n_out.entry_index      = rd_idx;
                    n_out.entry_mac        = rd_mac;
                    n_out.entry_first_seen = rd_first;
                    n_out.entry_last_seen  = rd_last;
                end
                default: begin
                end
            endcase
            n_out_valid         = !(take_byte && judge.pass);
            cnt_ext             = 8'(n_used);
            n_out.gateway_count = cnt_ext[2:0];
            n_out.alert         = n_alert;
        end
    end

    // Hold state, registers and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_used      <= '0;
            r_alert     <= 1'b0;
            r_now       <= '0;
            r_octet     <= 8'd1;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_used      <= n_used;
            r_alert     <= n_alert;
            if (in_acc && (i_in_item.cmd == CMD_TICK)) begin
                r_now <= r_now + 32'd1;
            end
            if (i_cfg_we) begin
                r_octet <= i_cfg_data;
            end
        end
        r_out  <= n_out;
        r_cand <= n_cand;
    end

endmodule

@@ src/agmcd_checker.sv @@
module agmcd_checker
    import agmcd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // Drop any result after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Hold a stalled result transaction
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // Raise the alert when a second gateway is added
    a_alert_on_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.event_res == EV_NEW)
            && (o_out_item.gateway_count > 3'd1) |-> o_out_item.alert)
        else $error("second gateway added without alert");

    // Report an empty table after a clear
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.event_res == EV_CLEARED)
            |-> (o_out_item.gateway_count == 3'd0) && !o_out_item.alert
                && (o_out_item.entry_mac == '0))
        else $error("clear result not empty");

    // Zero the entry index, MAC and last-seen time when the table is full
    a_full_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.event_res == EV_FULL)
            |-> (o_out_item.entry_index == 2'd0) && (o_out_item.entry_mac == '0)
                && (o_out_item.entry_last_seen == '0))
        else $error("full result carries an entry");

endmodule

bind arp_gateway_mac_conflict_detector agmcd_checker u_agmcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
